@@ rtl/assert_macros.svh @@
// Assertion macros shared by the chunker RTL.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ghcb_pkg.sv @@
// Shared types, codes and the gear table for the gear-hash chunker.
// No dependencies; used by ghcb_core and gear_hash_chunk_boundary_top.
package ghcb_pkg;

  // Cut reason codes
  localparam logic [1:0] REASON_HASH = 2'd0;
  localparam logic [1:0] REASON_MAX  = 2'd1;
  localparam logic [1:0] REASON_MIN  = 2'd2;
  localparam logic [1:0] REASON_END  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASK_LEN = 2'd0;
  localparam logic [1:0] CFG_MIN_SIZE = 2'd1;
  localparam logic [1:0] CFG_MAX_SIZE = 2'd2;

  localparam int HASH_W     = 64;
  localparam int GEAR_DEPTH = 256;
  localparam int MASK_W     = 7;

  localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MIX1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MIX2  = 64'h94D0_49BB_1331_11EB;

  typedef logic [HASH_W-1:0] gear_rom_t [GEAR_DEPTH];

  // Decision of the hash stage for one item
  typedef struct packed {
    logic       cut;
    logic [1:0] reason;
  } cut_t;

  // Settings derived from the configuration registers
  typedef struct packed {
    logic              min_ge;
    logic [HASH_W-1:0] top_mask;
  } cfg_ctl_t;

  // Splitmix64 sequence, evaluated at elaboration only
  function automatic gear_rom_t build_gear_rom();
    gear_rom_t   tbl;
    logic [63:0] s;
    logic [63:0] z;
    s = SM_GAMMA;
    for (int k = 0; k < GEAR_DEPTH; k++) begin
      s = s + SM_GAMMA;
      z = s;
      z = (z ^ (z >> 30)) * SM_MIX1;
      z = (z ^ (z >> 27)) * SM_MIX2;
      tbl[k] = z ^ (z >> 31);
    end
    return tbl;
  endfunction

  localparam gear_rom_t GEAR_ROM = build_gear_rom();

  // Mask over the top bits of the hash that must be zero for a boundary
  function automatic logic [HASH_W-1:0] top_mask(input logic [MASK_W-1:0] bits);
    logic [HASH_W-1:0] m;
    if (bits == '0) begin
      m = '0;
    end else if (bits >= MASK_W'(HASH_W)) begin
      m = '1;
    end else begin
      m = ~({HASH_W{1'b1}} >> bits);
    end
    return m;
  endfunction

endpackage

@@ rtl/ghcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ghcb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ghcb_core.sv @@
// Hash stage of the chunker: rolling gear hash, chunk counters and cut decision.
// Depends on ghcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ghcb_core #(
  parameter int LENGTH_BITS = 24,
  parameter int OFFSET_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_i,
  input  logic [63:0]             gear_i,
  input  logic                    eos_i,
  input  ghcb_pkg::cfg_ctl_t      cfg_i,
  input  logic [LENGTH_BITS-1:0]  min_i,
  input  logic [LENGTH_BITS-1:0]  maxv_i,
  output ghcb_pkg::cut_t          res_o,
  output logic [OFFSET_BITS-1:0]  start_o,
  output logic [LENGTH_BITS-1:0]  length_o
);

  logic [63:0]            hash_r, hash_nxt, hash_new;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, n;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, off_new;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   zero_top, hash_hit, min_hit, max_hit;
  ghcb_pkg::cut_t         res;

  // Fold the byte into the hash and count it
  assign hash_new = {hash_r[62:0], 1'b0} + gear_i;
  assign n        = cnt_r + LENGTH_BITS'(1);
  assign off_new  = off_r + OFFSET_BITS'(1);
  assign zero_top = (hash_new & cfg_i.top_mask) == '0;

  assign hash_hit = !cfg_i.min_ge && (n > min_i) && zero_top;
  assign min_hit  = cfg_i.min_ge && (n == min_i);
  assign max_hit  = !cfg_i.min_ge && (n == maxv_i);

  // Pick the cut reason by priority
  always_comb begin
    res.cut    = 1'b1;
    res.reason = ghcb_pkg::REASON_END;
    if (min_hit) begin
      res.reason = ghcb_pkg::REASON_MIN;
    end else if (hash_hit) begin
      res.reason = ghcb_pkg::REASON_HASH;
    end else if (max_hit) begin
      res.reason = ghcb_pkg::REASON_MAX;
    end else if (!eos_i) begin
      res.cut = 1'b0;
    end
  end

  assign res_o    = res;
  assign start_o  = start_r;
  assign length_o = n;

  // Next chunk state: restart after a cut, rewind the offset at stream end
  always_comb begin
    hash_nxt  = hash_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    start_nxt = start_r;
    if (step_i) begin
      if (res.cut) begin
        hash_nxt  = '0;
        cnt_nxt   = '0;
        off_nxt   = eos_i ? '0 : off_new;
        start_nxt = eos_i ? '0 : off_new;
      end else begin
        hash_nxt = hash_new;
        cnt_nxt  = n;
        off_nxt  = off_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      cnt_r   <= '0;
      off_r   <= '0;
      start_r <= '0;
    end else begin
      hash_r  <= hash_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
    end
  end

  `CHK_NEXT(a_end_clears, clk, rst_n, step_i && res.cut && eos_i, off_r == '0 && cnt_r == '0 && hash_r == '0, "stream end left chunk state behind")
  `CHK_IMPL(a_min_reason, clk, rst_n, step_i && res.cut && res.reason == ghcb_pkg::REASON_MIN, cfg_i.min_ge && n == min_i, "min-size cut without its condition")
  `CHK_IMPL(a_hash_reason, clk, rst_n, step_i && res.cut && res.reason == ghcb_pkg::REASON_HASH, !cfg_i.min_ge && n > min_i, "hash cut inside the minimum size")

endmodule

@@ rtl/gear_hash_chunk_boundary_top.sv @@
// Gear-hash chunker top level; uses ghcb_pkg, ghcb_ram, ghcb_core and assert_macros.svh.
// Result path: an accepted item passes the registered table read, then the hash stage; a cut is registered onto out_*.
// Throughput: one byte per cycle; after the table fill, in_tready drops only while a cut waits on a blocked output.
// Reset (rst_n low, synchronous) clears chunk state and loads register defaults, then a
// pass copies the 256-entry gear table into the RAM; in_tready stays low during that pass.
// Configuration writes apply from the next item to reach the hash stage.
`include "assert_macros.svh"

module gear_hash_chunk_boundary_top #(
  parameter int LENGTH_BITS = 24,
  parameter int OFFSET_BITS = 48
) (
  input  logic clk,
  input  logic rst_n,
  // Input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_stream
  // Result channel
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [((OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0]    out_tdata, // chunk_start, chunk_length
  output logic [1:0]                                      out_tuser, // cut_reason
  // Configuration port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [LENGTH_BITS-1:0] cfg_wdata
);

  localparam int OUT_W  = ((OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8;
  localparam int ADDR_W = $clog2(ghcb_pkg::GEAR_DEPTH);

  logic [ghcb_pkg::MASK_W-1:0] mask_len_r;
  logic [LENGTH_BITS-1:0]      min_r, max_r, maxv;
  ghcb_pkg::cfg_ctl_t          cfg_ctl;

  logic [ADDR_W-1:0] fill_idx_r;
  logic              fill_done_r;

  logic              s1_valid_r, s1_eos_r;
  logic [63:0]       gear_q;
  logic              stall, step;

  ghcb_pkg::cut_t         res;
  logic [OFFSET_BITS-1:0] res_start;
  logic [LENGTH_BITS-1:0] res_len;

  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] out_start_r;
  logic [LENGTH_BITS-1:0] out_len_r;
  logic [1:0]             out_reason_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_len_r <= ghcb_pkg::MASK_W'(13);
      min_r      <= LENGTH_BITS'(32'd2048);
      max_r      <= LENGTH_BITS'(32'd65536);
    end else if (cfg_we) begin
      case (cfg_index)
        ghcb_pkg::CFG_MASK_LEN: mask_len_r <= cfg_wdata[ghcb_pkg::MASK_W-1:0];
        ghcb_pkg::CFG_MIN_SIZE: min_r      <= cfg_wdata;
        ghcb_pkg::CFG_MAX_SIZE: max_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Derive compare settings from the registers
  always_comb begin
    maxv             = (max_r == '0) ? LENGTH_BITS'(1) : max_r;
    cfg_ctl.min_ge   = min_r >= maxv;
    cfg_ctl.top_mask = ghcb_pkg::top_mask(mask_len_r);
  end

  // Table fill pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_idx_r  <= '0;
      fill_done_r <= 1'b0;
    end else if (!fill_done_r) begin
      fill_idx_r <= fill_idx_r + ADDR_W'(1);
      if (fill_idx_r == ADDR_W'(ghcb_pkg::GEAR_DEPTH - 1)) begin
        fill_done_r <= 1'b1;
      end
    end
  end

  // Hold the pipeline only when a cut meets a full, blocked output register
  assign stall     = s1_valid_r && res.cut && out_valid_r && !out_tready;
  assign in_tready = fill_done_r && !stall;
  assign step      = s1_valid_r && !stall;

  ghcb_ram #(
    .WIDTH (ghcb_pkg::HASH_W),
    .DEPTH (ghcb_pkg::GEAR_DEPTH)
  ) u_gear_ram (
    .clk   (clk),
    .we    (!fill_done_r),
    .waddr (fill_idx_r),
    .wdata (ghcb_pkg::GEAR_ROM[fill_idx_r]),
    .re    (!stall),
    .raddr (in_tdata[ADDR_W-1:0]),
    .rdata (gear_q)
  );

  // Track the item whose table word is being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_eos_r <= in_tlast;
    end
  end

  ghcb_core #(
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .gear_i   (gear_q),
    .eos_i    (s1_eos_r),
    .cfg_i    (cfg_ctl),
    .min_i    (min_r),
    .maxv_i   (maxv),
    .res_o    (res),
    .start_o  (res_start),
    .length_o (res_len)
  );

  // Output register: load on a cut, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.cut) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.cut) begin
      out_start_r  <= res_start;
      out_len_r    <= res_len;
      out_reason_r <= res.reason;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_len_r, out_start_r});
  assign out_tuser  = out_reason_r;

  `CHK_IMPL(a_no_item_in_fill, clk, rst_n, !fill_done_r, !s1_valid_r && !out_valid_r, "item in flight during table fill")
  `CHK_NEXT(a_fill_stays_done, clk, rst_n, fill_done_r, fill_done_r, "table fill restarted without reset")
  `CHK_NEXT(a_stall_keeps_item, clk, rst_n, stall, s1_valid_r, "stalled item lost from the hash stage")

endmodule
